// ===== hw/rtl/trd_pkg.sv =====
// Shared types and constants of the timed rigid transform deskew block.
`default_nettype none

package trd_pkg;

  // Table geometry.
  localparam int TABLE_ENTRIES   = 64;
  localparam int WORDS_PER_ENTRY = 12;
  localparam int WORD_W          = 32;
  localparam int ROW_W           = WORDS_PER_ENTRY * WORD_W;
  localparam int SLOT_W          = $clog2(TABLE_ENTRIES);
  localparam int USED_W          = $clog2(TABLE_ENTRIES + 1);

  // Divider widths: the remainder never exceeds the non-negative time.
  localparam int LEN_W = 31;
  localparam int REM_W = 31;
  localparam int DIV_W = LEN_W + SLOT_W;

  // Lane positions within a table row.
  localparam int LANE_TX = 9;

  // Item commands.
  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_POINT = 1'b1
  } cmd_e;

  // Configuration register indexes.
  localparam logic REG_SLOT_LEN = 1'b0;
  localparam logic REG_ENTRIES  = 1'b1;

  // One input item without its time stamp.
  typedef struct packed {
    cmd_e               cmd;
    logic [5:0]         ent;
    logic [3:0]         elem;
    logic signed [31:0] val;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               pv;
  } item_t;

  // An item while its slot is being worked out.
  typedef struct packed {
    item_t             it;
    logic [REM_W-1:0]  rem;
    logic [SLOT_W-1:0] q;
    logic              big;
  } div_t;

  // An item with its table entry resolved.
  typedef struct packed {
    item_t             it;
    logic [SLOT_W-1:0] slot;
    logic              late;
  } slot_t;

  // One result item.
  typedef struct packed {
    logic signed [31:0] x_out;
    logic signed [31:0] y_out;
    logic signed [31:0] z_out;
    logic signed [31:0] x_raw;
    logic signed [31:0] y_raw;
    logic signed [31:0] z_raw;
    logic [5:0]         entry_used;
    logic               clamped_late;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/trd_ram.sv =====
// Generic single-port RAM with lane write enables and registered read.
`default_nettype none

module trd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int LANES = 1
) (
  input  wire logic                     clk_i,
  input  wire logic [LANES-1:0]         we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH/LANES-1:0]   wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  localparam int LaneW = WIDTH / LANES;

  logic [WIDTH-1:0] mem [DEPTH];

  // Lane writes and a registered read that holds between reads.
  always_ff @(posedge clk_i) begin
    for (int l = 0; l < LANES; l++) begin
      if (we_i[l]) begin
        mem[addr_i][l*LaneW +: LaneW] <= wdata_i;
      end
    end
    if (re_i) begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/trd_slot_div.sv =====
// Pipelined slot divider: one quotient bit per stage, then clamping.
`default_nettype none

module trd_slot_div (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire trd_pkg::item_t       in_item_i,
  input  wire logic signed [31:0]   time_i,
  input  wire logic [30:0]          slot_len_i,
  input  wire logic [6:0]           entries_i,
  output logic                      out_valid_o,
  input  wire logic                 out_free_i,
  output trd_pkg::slot_t            out_o
);
  import trd_pkg::*;

  div_t              st_q [SLOT_W+1];
  logic              v_q  [SLOT_W+1];
  logic [SLOT_W+1:0] free;
  logic [LEN_W-1:0]  len;
  logic [USED_W-1:0] used;
  div_t              st_in;
  logic              late;

  // One restoring step for quotient bit b.
  function automatic div_t div_step(div_t s, logic [LEN_W-1:0] l, int b);
    logic [DIV_W-1:0] d;
    d = DIV_W'(l) << b;
    if (DIV_W'(s.rem) >= d) begin
      s.rem  = s.rem - REM_W'(d);
      s.q[b] = 1'b1;
    end
    return s;
  endfunction

  // Effective configuration: zero length or zero entries act as one, entries clamp to the table.
  always_comb begin
    len = (slot_len_i == '0) ? LEN_W'(1) : slot_len_i;
    if (entries_i == '0) begin
      used = USED_W'(1);
    end else if (32'(entries_i) > TABLE_ENTRIES) begin
      used = USED_W'(TABLE_ENTRIES);
    end else begin
      used = USED_W'(entries_i);
    end
  end

  // Negative times take slot zero; a time of table size or more is flagged early.
  always_comb begin
    st_in.it  = in_item_i;
    st_in.q   = '0;
    st_in.rem = time_i[31] ? '0 : REM_W'(time_i[30:0]);
    st_in.big = !time_i[31] && ((DIV_W+1)'(time_i[30:0]) >= ((DIV_W+1)'(len) << SLOT_W));
  end

  // Stage occupancy: a stage takes a new item when empty or emptying.
  always_comb begin
    free[SLOT_W+1] = out_free_i;
    for (int i = SLOT_W; i >= 0; i--) begin
      free[i] = !v_q[i] || free[i+1];
    end
  end

  assign in_stall_o = !free[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= SLOT_W; i++) begin
        v_q[i] <= 1'b0;
      end
    end else begin
      if (free[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int i = 1; i <= SLOT_W; i++) begin
        if (free[i]) begin
          v_q[i] <= v_q[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (free[0] && in_valid_i) begin
      st_q[0] <= st_in;
    end
    for (int i = 1; i <= SLOT_W; i++) begin
      if (free[i] && v_q[i-1]) begin
        st_q[i] <= div_step(st_q[i-1], len, SLOT_W - i);
      end
    end
  end

  // Clamp the quotient to the last entry in use.
  assign late = st_q[SLOT_W].big || (USED_W'(st_q[SLOT_W].q) >= used);

  always_comb begin
    out_o.it   = st_q[SLOT_W].it;
    out_o.late = late;
    out_o.slot = late ? SLOT_W'(used - USED_W'(1)) : st_q[SLOT_W].q;
  end

  assign out_valid_o = v_q[SLOT_W];

  // A late slot always names the last entry in use.
  a_late_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.late) |-> (out_o.slot == SLOT_W'(used - USED_W'(1))))
    else $error("late slot is not the last entry in use");

  // A stalled final stage keeps its item.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_free_i) |=> out_valid_o)
    else $error("divider dropped a stalled item");

  // An early slot is below the entries in use.
  a_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_o.late) |-> (USED_W'(out_o.slot) < used))
    else $error("early slot beyond entries in use");

endmodule

`default_nettype wire

// ===== hw/rtl/trd_xform.sv =====
// Rotation, rounding, translation and saturation pipeline with the output register.
`default_nettype none

module trd_xform (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_free_o,
  input  wire trd_pkg::slot_t              in_i,
  input  wire logic [trd_pkg::ROW_W-1:0]   row_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output trd_pkg::result_t                 out_o
);
  import trd_pkg::*;

  localparam logic signed [65:0] RoundHalf = 66'sh20000000;
  localparam logic signed [36:0] SatMax    = 37'sh007FFFFFFF;
  localparam logic signed [36:0] SatMin    = 37'sh1F80000000;

  logic               m_v_q, a_v_q, o_v_q;
  logic               m_free, a_free, o_free;
  slot_t              m_it_q, a_it_q;
  logic signed [63:0] m_prod_q [3][3];
  logic signed [31:0] m_tr_q   [3];
  logic signed [65:0] a_sum_q  [3];
  logic signed [31:0] a_tr_q   [3];
  logic signed [31:0] coord    [3];
  logic signed [31:0] res      [3];
  result_t            o_q;

  assign coord[0] = in_i.it.x;
  assign coord[1] = in_i.it.y;
  assign coord[2] = in_i.it.z;

  // Stage occupancy from the output backwards.
  assign o_free    = !o_v_q || !out_stall_i;
  assign a_free    = !a_v_q || o_free;
  assign m_free    = !m_v_q || a_free;
  assign in_free_o = m_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
      a_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else begin
      if (m_free) m_v_q <= in_valid_i;
      if (a_free) a_v_q <= m_v_q;
      if (o_free) o_v_q <= a_v_q;
    end
  end

  // Multiply stage: nine exact rotation products.
  always_ff @(posedge clk_i) begin
    if (m_free && in_valid_i) begin
      m_it_q <= in_i;
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          m_prod_q[k][j] <= $signed(row_i[WORD_W*(3*k+j) +: WORD_W]) * coord[j];
        end
        m_tr_q[k] <= $signed(row_i[WORD_W*(LANE_TX+k) +: WORD_W]);
      end
    end
  end

  // Sum stage: exact row sums with the rounding half added.
  always_ff @(posedge clk_i) begin
    if (a_free && m_v_q) begin
      a_it_q <= m_it_q;
      for (int k = 0; k < 3; k++) begin
        a_sum_q[k] <= 66'(m_prod_q[k][0]) + 66'(m_prod_q[k][1]) + 66'(m_prod_q[k][2])
                      + RoundHalf;
        a_tr_q[k]  <= m_tr_q[k];
      end
    end
  end

  // Scale, translate and saturate each coordinate.
  always_comb begin
    logic signed [36:0] r;
    for (int k = 0; k < 3; k++) begin
      r = 37'($signed(a_sum_q[k][65:30])) + 37'(a_tr_q[k]);
      if (r > SatMax) begin
        res[k] = SatMax[31:0];
      end else if (r < SatMin) begin
        res[k] = SatMin[31:0];
      end else begin
        res[k] = r[31:0];
      end
    end
  end

  // Output register; points without a return pass through unchanged.
  always_ff @(posedge clk_i) begin
    if (o_free && a_v_q) begin
      o_q.x_raw <= a_it_q.it.x;
      o_q.y_raw <= a_it_q.it.y;
      o_q.z_raw <= a_it_q.it.z;
      if (a_it_q.it.pv) begin
        o_q.x_out        <= res[0];
        o_q.y_out        <= res[1];
        o_q.z_out        <= res[2];
        o_q.entry_used   <= 6'(a_it_q.slot);
        o_q.clamped_late <= a_it_q.late;
      end else begin
        o_q.x_out        <= a_it_q.it.x;
        o_q.y_out        <= a_it_q.it.y;
        o_q.z_out        <= a_it_q.it.z;
        o_q.entry_used   <= '0;
        o_q.clamped_late <= 1'b0;
      end
    end
  end

  assign out_valid_o = o_v_q;
  assign out_o       = o_q;

  // A filled sum stage moves on only when the output can take it.
  a_sum_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_v_q && !o_free) |=> a_v_q)
    else $error("sum stage lost an item");

  // A product stage item is never overwritten while blocked.
  a_mul_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_v_q && !a_free) |=> (m_v_q && $stable(m_it_q)))
    else $error("product stage overwritten while blocked");

  // A stalled result holds its value until the transfer.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_v_q && out_stall_i) |=> (o_v_q && $stable(o_q)))
    else $error("result changed while stalled");

endmodule

`default_nettype wire

// ===== hw/rtl/timed_rigid_transform_deskew.sv =====
// Top level of the lidar ego-motion deskew block.
//
// Usage: items enter on the input channel (valid/stall); a load item writes one
// word of the transform table, a point item yields one result on the output
// channel. A point picks entry floor(time / slot length), slot zero for negative
// times, and clamps to the last entry in use with the late flag set; it is then
// rotated and translated with saturation. Points without a return pass through.
// Throughput is one item per cycle when the receiver does not stall, set by
// the single table port, which reads one whole row of twelve words per point
// or writes one word per load; a quotient bit is resolved per stage of the
// slot divider.
// Loads are written to the table at the same pipeline position where points
// read it, so every point sees exactly the loads accepted before it.
// When the receiver stalls, the result waits in the output register while the
// stages behind it keep filling; input stall rises only once all are full.
// Reset empties the pipeline and sets the slot length to 2777778 ns and the
// entries in use to 37; the table holds no defined data until written.
// Configuration registers sit on the APB port at byte addresses 0 and 4.
`default_nettype none

module timed_rigid_transform_deskew (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Configuration port.
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  // Input channel.
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               command_i,
  input  wire logic [5:0]         entry_index_i,
  input  wire logic [3:0]         element_index_i,
  input  wire logic signed [31:0] element_value_i,
  input  wire logic signed [31:0] x_in_i,
  input  wire logic signed [31:0] y_in_i,
  input  wire logic signed [31:0] z_in_i,
  input  wire logic               point_valid_i,
  input  wire logic signed [31:0] time_ns_i,
  // Output channel.
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      x_out_o,
  output logic signed [31:0]      y_out_o,
  output logic signed [31:0]      z_out_o,
  output logic signed [31:0]      x_raw_o,
  output logic signed [31:0]      y_raw_o,
  output logic signed [31:0]      z_raw_o,
  output logic [5:0]              entry_used_o,
  output logic                    clamped_late_o
);
  import trd_pkg::*;

  logic [30:0]                slot_len_q;
  logic [6:0]                 entries_q;
  item_t                      in_item;
  logic                       div_valid;
  slot_t                      div_out;
  slot_t                      r_q;
  logic                       r_v_q;
  logic                       r_free;
  logic                       m_free;
  logic                       take;
  logic                       is_load;
  logic                       ram_re;
  logic [WORDS_PER_ENTRY-1:0] ram_we;
  logic [SLOT_W-1:0]          ram_addr;
  logic [ROW_W-1:0]           ram_row;
  result_t                    res;

  // Configuration registers; the upper address bit selects the register.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_len_q <= 31'd2777778;
      entries_q  <= 7'd37;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_SLOT_LEN: slot_len_q <= pwdata[30:0];
        REG_ENTRIES:  entries_q  <= pwdata[6:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SLOT_LEN: prdata = {1'b0, slot_len_q};
      REG_ENTRIES:  prdata = {25'b0, entries_q};
      default:      prdata = '0;
    endcase
  end

  // Input item gathered into one word.
  always_comb begin
    in_item.cmd  = cmd_e'(command_i);
    in_item.ent  = entry_index_i;
    in_item.elem = element_index_i;
    in_item.val  = element_value_i;
    in_item.x    = x_in_i;
    in_item.y    = y_in_i;
    in_item.z    = z_in_i;
    in_item.pv   = point_valid_i;
  end

  trd_slot_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item),
    .time_i      (time_ns_i),
    .slot_len_i  (slot_len_q),
    .entries_i   (entries_q),
    .out_valid_o (div_valid),
    .out_free_i  (r_free),
    .out_o       (div_out)
  );

  // Table access stage: loads write a word, points read their row.
  assign r_free  = !r_v_q || (r_q.it.cmd == CMD_LOAD) || m_free;
  assign take    = div_valid && r_free;
  assign is_load = (div_out.it.cmd == CMD_LOAD);
  assign ram_re  = take && !is_load;

  always_comb begin
    for (int l = 0; l < WORDS_PER_ENTRY; l++) begin
      ram_we[l] = take && is_load && (div_out.it.elem == 4'(l))
                  && (32'(div_out.it.ent) < TABLE_ENTRIES);
    end
    ram_addr = is_load ? SLOT_W'(div_out.it.ent) : div_out.slot;
  end

  trd_ram #(
    .WIDTH (ROW_W),
    .DEPTH (TABLE_ENTRIES),
    .LANES (WORDS_PER_ENTRY)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (div_out.it.val),
    .rdata_o (ram_row)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_v_q <= 1'b0;
    end else if (r_free) begin
      r_v_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      r_q <= div_out;
    end
  end

  trd_xform u_xform (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (r_v_q && (r_q.it.cmd == CMD_POINT)),
    .in_free_o   (m_free),
    .in_i        (r_q),
    .row_i       (ram_row),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (res)
  );

  assign x_out_o        = res.x_out;
  assign y_out_o        = res.y_out;
  assign z_out_o        = res.z_out;
  assign x_raw_o        = res.x_raw;
  assign y_raw_o        = res.y_raw;
  assign z_raw_o        = res.z_raw;
  assign entry_used_o   = res.entry_used;
  assign clamped_late_o = res.clamped_late;

  // The single table port never reads and writes in one cycle.
  a_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_re && (ram_we != '0)))
    else $error("table read and write in the same cycle");

  // A row read always lands in a filled access stage holding a point.
  a_read_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |=> (r_v_q && (r_q.it.cmd == CMD_POINT)))
    else $error("row read without a point to take it");

  // A blocked point in the access stage keeps its row.
  a_row_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (r_v_q && (r_q.it.cmd == CMD_POINT) && !m_free) |=> $stable(ram_row))
    else $error("row changed under a blocked point");

endmodule

`default_nettype wire

// ===== tb/timed_rigid_transform_deskew_tb.sv =====
// Self-checking testbench of the timed rigid transform deskew block.
`default_nettype none

// Scoreboard: its own copy of the transform table and registers, and the
// queue of expected results still awaited from the block.
class deskew_scoreboard;
  logic [31:0]              table_words [trd_pkg::TABLE_ENTRIES*trd_pkg::WORDS_PER_ENTRY];
  logic [30:0]              slot_len;
  logic [6:0]               entries;
  trd_pkg::result_t         pending_points [$];
  int                       mismatches;

  function void reset_state();
    foreach (table_words[i]) table_words[i] = '0;
    slot_len = 31'd2777778;
    entries  = 7'd37;
    pending_points.delete();
    mismatches = 0;
  endfunction

  function void write_register(logic reg_idx, logic [31:0] value);
    if (reg_idx == trd_pkg::REG_SLOT_LEN) slot_len = value[30:0];
    else entries = value[6:0];
  endfunction

  // One output coordinate: exact row sum, rounded half up, plus translation, saturated.
  function logic signed [31:0] apply_row(int base, int row, logic signed [31:0] p [3]);
    logic signed [65:0] acc;
    logic signed [65:0] a;
    logic signed [65:0] b;
    logic signed [31:0] tr;
    acc = '0;
    for (int j = 0; j < 3; j++) begin
      a = $signed(table_words[base + row*3 + j]);
      b = p[j];
      acc += a * b;
    end
    acc = (acc + (66'sd1 <<< 29)) >>> 30;
    tr = $signed(table_words[base + trd_pkg::LANE_TX + row]);
    acc += tr;
    if (acc > 66'sh7fffffff) return 32'sh7fffffff;
    if (acc < -66'sh80000000) return 32'sh80000000;
    return acc[31:0];
  endfunction

  // Note one accepted transfer on the input channel.
  function void note_item(trd_pkg::item_t it, logic signed [31:0] t);
    trd_pkg::result_t r;
    logic signed [31:0] p [3];
    logic [63:0] len;
    logic [63:0] used;
    logic [63:0] slot;
    if (it.cmd == trd_pkg::CMD_LOAD) begin
      if (it.elem < trd_pkg::WORDS_PER_ENTRY)
        table_words[it.ent*trd_pkg::WORDS_PER_ENTRY + it.elem] = it.val;
      return;
    end
    p[0] = it.x; p[1] = it.y; p[2] = it.z;
    r.x_raw = it.x; r.y_raw = it.y; r.z_raw = it.z;
    if (!it.pv) begin
      r.x_out = it.x; r.y_out = it.y; r.z_out = it.z;
      r.entry_used = '0;
      r.clamped_late = 1'b0;
    end else begin
      used = (entries == 0) ? 64'd1 : (entries > trd_pkg::TABLE_ENTRIES) ?
             64'(trd_pkg::TABLE_ENTRIES) : 64'(entries);
      len = (slot_len == 0) ? 64'd1 : 64'(slot_len);
      slot = t[31] ? 64'd0 : 64'(t[30:0]) / len;
      r.clamped_late = 1'b0;
      if (slot >= used) begin
        slot = used - 1;
        r.clamped_late = 1'b1;
      end
      r.x_out = apply_row(int'(slot)*trd_pkg::WORDS_PER_ENTRY, 0, p);
      r.y_out = apply_row(int'(slot)*trd_pkg::WORDS_PER_ENTRY, 1, p);
      r.z_out = apply_row(int'(slot)*trd_pkg::WORDS_PER_ENTRY, 2, p);
      r.entry_used = slot[5:0];
    end
    pending_points = {pending_points, r};
  endfunction

  // Compare one transfer on the output channel with the oldest expected point.
  function void check_result(trd_pkg::result_t got);
    trd_pkg::result_t want;
    if (pending_points.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result: %p", got);
      return;
    end
    want = pending_points.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch: out exp %h %h %h got %h %h %h",
                 want.x_out, want.y_out, want.z_out, got.x_out, got.y_out, got.z_out);
        $display("  raw exp %h %h %h got %h %h %h | entry exp %0d got %0d | late exp %b got %b",
                 want.x_raw, want.y_raw, want.z_raw, got.x_raw, got.y_raw, got.z_raw,
                 want.entry_used, got.entry_used, want.clamped_late, got.clamped_late);
      end
    end
  endfunction
endclass

module timed_rigid_transform_deskew_tb;
  import trd_pkg::*;

  localparam int WATCHDOG_LIMIT   = 5000;
  // Entries loaded at the start: the first few, the last in use after reset
  // and the last of the table.
  localparam int FILL_ENTRIES     = 8;
  localparam int RESET_LAST_ENTRY = 36;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        command_i = 1'b0;
  logic [5:0]  entry_index_i = '0;
  logic [3:0]  element_index_i = '0;
  logic signed [31:0] element_value_i = '0;
  logic signed [31:0] x_in_i = '0;
  logic signed [31:0] y_in_i = '0;
  logic signed [31:0] z_in_i = '0;
  logic        point_valid_i = 1'b0;
  logic signed [31:0] time_ns_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic signed [31:0] x_out_o, y_out_o, z_out_o;
  logic signed [31:0] x_raw_o, y_raw_o, z_raw_o;
  logic [5:0]  entry_used_o;
  logic        clamped_late_o;

  deskew_scoreboard sb = new();
  int          idle_cycles = 0;
  int          stall_left = 0;
  bit          calm = 1'b0;

  timed_rigid_transform_deskew i_dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Mostly short gaps, now and then a long one; none at all in calm stretches.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Receiver stall pattern on the output channel.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(99) < 25) begin
      out_stall_i <= 1'b1;
      stall_left <= pick_gap();
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Result monitor and watchdog.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result('{x_out_o, y_out_o, z_out_o, x_raw_o, y_raw_o, z_raw_o,
                        entry_used_o, clamped_late_o});
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timed_rigid_transform_deskew_tb: FAIL");
      $finish;
    end
  end

  // Present one item and hold it until the transfer; optionally idle after it.
  task automatic send_item(item_t it, logic signed [31:0] t);
    int gap;
    command_i       <= it.cmd;
    entry_index_i   <= it.ent;
    element_index_i <= it.elem;
    element_value_i <= it.val;
    x_in_i          <= it.x;
    y_in_i          <= it.y;
    z_in_i          <= it.z;
    point_valid_i   <= it.pv;
    time_ns_i       <= t;
    in_valid_i      <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_item(it, t);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic load_word(int ent, int elem, logic [31:0] val);
    item_t it;
    it = '{cmd: CMD_LOAD, ent: ent[5:0], elem: elem[3:0], val: val,
           x: $urandom, y: $urandom, z: $urandom, pv: 1'($urandom_range(1))};
    send_item(it, $urandom);
  endtask

  task automatic send_point(logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] z, logic pv, logic signed [31:0] t);
    item_t it;
    it = '{cmd: CMD_POINT, ent: 6'($urandom), elem: 4'($urandom), val: $urandom,
           x: x, y: y, z: z, pv: pv};
    send_item(it, t);
  endtask

  // Withdraw the last item at once, wait for every expected result, then
  // let the pipeline run dry.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_points.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic apb_write(logic reg_idx, logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.write_register(reg_idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2, 3: return $urandom_range(32'h000fffff) - 32'h00080000;
      default: return $urandom;
    endcase
  endfunction

  // Rotation words near the unit range keep most results unsaturated.
  function automatic logic [31:0] pick_word(int elem);
    if (elem < LANE_TX && $urandom_range(1))
      return $urandom_range(32'h7fffffff) - 32'h40000000 >>> 0;
    if (elem >= LANE_TX && $urandom_range(1))
      return $urandom_range(32'h00ffffff) - 32'h00800000;
    return $urandom;
  endfunction

  // Entries that hold a full transform from the start of the run.
  function automatic bit is_loaded(int e);
    return (e < FILL_ENTRIES) || (e == RESET_LAST_ENTRY) || (e == TABLE_ENTRIES - 1);
  endfunction

  // Times that reach loaded entries only: early, last in use, late or negative.
  function automatic logic [31:0] pick_time(logic [30:0] len, logic [6:0] ent);
    logic [63:0] l;
    logic [63:0] used;
    logic [63:0] s;
    logic [63:0] t;
    l = (len == '0) ? 64'd1 : 64'(len);
    used = (ent == '0) ? 64'd1 : (ent > TABLE_ENTRIES) ? 64'(TABLE_ENTRIES) : 64'(ent);
    case ($urandom_range(5))
      0: return 32'h80000000 | $urandom;
      1: s = used - 64'd1;
      2: s = used + 64'($urandom_range(3));
      default: s = 64'($urandom_range(FILL_ENTRIES - 1)) % used;
    endcase
    t = s * l + 64'($urandom_range(32'(l - 64'd1)));
    if (t > 64'h7fffffff) t = 64'h7fffffff;
    s = t / l;
    if (s >= used) s = used - 64'd1;
    if (!is_loaded(int'(s))) t = 64'($urandom_range(32'(l - 64'd1)));
    return t[31:0];
  endfunction

  task automatic random_phase(int count);
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) calm = ($urandom_range(3) == 0);
      case ($urandom_range(9))
        0: load_word($urandom_range(63), $urandom_range(11), pick_word($urandom_range(11)));
        1: load_word($urandom_range(63), $urandom_range(15, 12), $urandom);
        default: send_point(pick_coord(), pick_coord(), pick_coord(),
                            $urandom_range(7) != 0, pick_time(sb.slot_len, sb.entries));
      endcase
    end
    calm = 1'b0;
    drain();
  endtask

  initial begin
    sb.reset_state();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill every entry that a point can reach so that none reads an unwritten word.
    for (int e = 0; e < TABLE_ENTRIES; e++)
      if (is_loaded(e))
        for (int w = 0; w < WORDS_PER_ENTRY; w++)
          load_word(e, w, pick_word(w));

    // Directed: identity entry 0 with translation, extreme entry 1.
    for (int w = 0; w < 9; w++) load_word(0, w, (w % 4 == 0) ? 32'h40000000 : 32'h0);
    load_word(0, 9, 32'h00010000);
    load_word(0, 10, 32'hffff0000);
    load_word(0, 11, 32'h7fffffff);
    for (int w = 0; w < 12; w++) load_word(1, w, (w % 2) ? 32'h80000000 : 32'h7fffffff);
    // Loads with a word index past the entry are ignored.
    load_word(0, 12, 32'hdeadbeef);
    load_word(0, 15, 32'h12345678);
    send_point(32'h00010000, 32'h00020000, 32'h0, 1'b1, 32'd0);
    send_point(32'h7fffffff, 32'h80000000, 32'h7fffffff, 1'b1, 32'h80000000);
    send_point(32'h80000000, 32'h80000000, 32'h80000000, 1'b1, -32'sd1);
    send_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b1, 32'd2777778);
    send_point(32'h80000000, 32'h7fffffff, 32'h80000000, 1'b1, 32'd2777777);
    send_point(32'h12345678, 32'h9abcdef0, 32'hffffffff, 1'b0, 32'd5);
    send_point(32'h00000001, 32'hffffffff, 32'h0, 1'b1, 32'h7fffffff);
    send_point(32'h00000001, 32'hffffffff, 32'h0, 1'b1, 32'd102777786);
    random_phase(50);

    // Shortest slot, every entry in use.
    apb_write(REG_SLOT_LEN, 32'd1);
    apb_write(REG_ENTRIES, 32'd64);
    send_point(32'h00010000, 32'h0, 32'h0, 1'b1, 32'd63);
    send_point(32'h00010000, 32'h0, 32'h0, 1'b1, 32'd64);
    random_phase(50);

    // Longest slot, one entry.
    apb_write(REG_SLOT_LEN, 32'h7fffffff);
    apb_write(REG_ENTRIES, 32'd1);
    send_point(32'h00010000, 32'h0, 32'h0, 1'b1, 32'h7fffffff);
    random_phase(40);

    // Zero slot length acts as one; zero entries act as one.
    apb_write(REG_SLOT_LEN, 32'h80000000);
    apb_write(REG_ENTRIES, 32'd0);
    random_phase(40);

    // Entries above the table size clamp to the table.
    apb_write(REG_SLOT_LEN, 32'hffffff00);
    apb_write(REG_ENTRIES, 32'hffffff7f);
    random_phase(40);

    apb_write(REG_SLOT_LEN, $urandom_range(32'h00ffffff, 1));
    apb_write(REG_ENTRIES, $urandom_range(FILL_ENTRIES, 2));
    random_phase(40);

    if (sb.mismatches == 0 && sb.pending_points.size() == 0)
      $display("timed_rigid_transform_deskew_tb: PASS");
    else
      $display("timed_rigid_transform_deskew_tb: FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
hw/rtl/trd_pkg.sv
hw/rtl/trd_ram.sv
hw/rtl/trd_slot_div.sv
hw/rtl/trd_xform.sv
hw/rtl/timed_rigid_transform_deskew.sv
tb/timed_rigid_transform_deskew_tb.sv
